/* hdl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Shortest path unit package
// Shared widths, register and command codes, beat types and state encoding.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int EDGES_DEFAULT = 256;

    localparam int NODE_FIELD_W = 6;
    localparam int COST_W       = 16;
    localparam int DIST_W       = 22;
    localparam int KIND_W       = 2;
    localparam int COUNT_REG_W  = 7;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [DIST_W-1:0]      DIST_MAX         = '1;
    localparam logic [COUNT_REG_W-1:0] NODE_COUNT_RESET = 7'd64;

    // Command codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

    // Register index, taken from address bit 2.
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [NODE_FIELD_W-1:0] from_node;
        logic [NODE_FIELD_W-1:0] to_node;
        logic [COST_W-1:0]       edge_cost;
        logic [NODE_FIELD_W-1:0] root_node;
    } t_in;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] node_index;
        logic [DIST_W-1:0]       distance;
        logic                    reachable;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] src;
        logic [NODE_FIELD_W-1:0] dst;
        logic [COST_W-1:0]       weight;
    } t_edge;

    typedef struct packed {
        logic              settled;
        logic              reached;
        logic [DIST_W-1:0] path_cost;
    } t_node;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ROOT,
        S_SCAN,
        S_SCAN_LAST,
        S_SETTLE,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_NODE_UPD,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

/* hdl/single_source_shortest_path_unit.sv */
// ----------------------------------------------------------------------------
// Single-source shortest path unit
// Stores directed weighted edges and, on a run beat, finds the least path
// cost from a root to every node by repeated least-distance scans.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Content
//  in       input      i_in_valid / o_in_ready   t_in: add edge, clear, run
//  out      output     o_out_valid / i_out_ready t_out: one beat per node
//  cfg      input      APB psel/penable/pwrite   node_count at address 0
//
//  Add and clear beats are done in the idle state. A run with S reachable
//  nodes clears the node memory, seeds the root, then makes S+1 scans for
//  the least-distance reached, unsettled node (none if the root is out of
//  range); after each scan that finds one, it settles that node and reads
//  every stored edge, reading and, if the path is shorter, updating the node
//  memory for each edge leaving that node to a node in use. Results then
//  follow one beat per node while the sink is ready. After reset the unit is
//  idle with an empty edge store; a stalled output beat holds the unit until taken.
//
module single_source_shortest_path_unit #(
    parameter int MAX_NODES = ssp_pkg::NODES_DEFAULT,
    parameter int MAX_EDGES = ssp_pkg::EDGES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ssp_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ssp_pkg::t_out                o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssp_pkg::PADDR_W-1:0]  paddr,
    input  logic [ssp_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

    ssp_pkg::t_state r_state, n_state;

    logic [ssp_pkg::COUNT_REG_W-1:0] r_node_count;
    logic [ECNT_W-1:0]               r_stored;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                r_nidx;
    logic [ECNT_W-1:0]               r_eidx;
    logic [ssp_pkg::NODE_FIELD_W-1:0] r_root;
    logic                            r_scan_v;
    logic [NODE_W-1:0]               r_scan_idx;
    logic                            r_found;
    logic [NODE_W-1:0]               r_pick;
    logic [ssp_pkg::DIST_W-1:0]      r_best_dist;
    logic [ssp_pkg::DIST_W-1:0]      r_nd;
    logic [NODE_W-1:0]               r_dst;
    logic                            r_out_valid;
    ssp_pkg::t_out                   r_out;

    logic                 in_fire, out_fire, out_free, cfg_write;
    logic [CNT_W-1:0]     run_count;
    logic [CNT_W-1:0]     last_idx;
    logic                 at_last;
    logic                 root_ok;
    logic                 edges_done;
    logic                 edge_hit;
    logic                 scan_take;
    logic                 n_found;
    logic [ssp_pkg::DIST_W-1:0] cand_dist;

    logic                 edge_we, edge_re;
    logic [EDGE_AW-1:0]   edge_waddr, edge_raddr;
    ssp_pkg::t_edge       edge_wdata, edge_rd;

    logic                 node_we, node_re;
    logic [NODE_W-1:0]    node_waddr, node_raddr;
    ssp_pkg::t_node       node_wdata, node_rd;

    function automatic logic [ssp_pkg::DIST_W-1:0] sat_add(
        input logic [ssp_pkg::DIST_W-1:0] a,
        input logic [ssp_pkg::COST_W-1:0] b
    );
        logic [ssp_pkg::DIST_W:0] s;
        s = {1'b0, a} + (ssp_pkg::DIST_W + 1)'(b);
        return s[ssp_pkg::DIST_W] ? ssp_pkg::DIST_MAX : s[ssp_pkg::DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    ssp_ram #(
        .WIDTH ($bits(ssp_pkg::t_edge)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rd)
    );

    ssp_ram #(
        .WIDTH ($bits(ssp_pkg::t_node)),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rd)
    );

    // ------------------------------------------------------------------------
    // Handshakes and configuration port
    // ------------------------------------------------------------------------
    assign o_in_ready  = (r_state == ssp_pkg::S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_fire    = r_out_valid && i_out_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ssp_pkg::REG_NODE_COUNT);
    assign prdata    = (paddr[2] == ssp_pkg::REG_NODE_COUNT) ?
                       ssp_pkg::PDATA_W'(r_node_count) : '0;

    always_comb begin
        if (32'(r_node_count) > 32'(MAX_NODES)) begin
            run_count = CNT_W'(MAX_NODES);
        end else begin
            run_count = CNT_W'(r_node_count);
        end
    end

    assign last_idx   = r_count - CNT_W'(1);
    assign at_last    = (r_nidx == last_idx);
    assign root_ok    = (32'(r_root) < 32'(r_count));
    assign edges_done = (r_eidx >= r_stored);
    // The source test also covers the node range, since the pick is in range.
    assign edge_hit   = (32'(edge_rd.src) == 32'(r_pick)) &&
                        (32'(edge_rd.dst) < 32'(r_count));
    assign cand_dist  = sat_add(r_best_dist, edge_rd.weight);

    assign scan_take = r_scan_v && node_rd.reached && !node_rd.settled &&
                       (!r_found || (node_rd.path_cost < r_best_dist));
    assign n_found   = r_found || scan_take;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssp_pkg::S_IDLE: begin
                if (in_fire && (i_in_data.kind == ssp_pkg::KIND_RUN) &&
                    (run_count != '0)) begin
                    n_state = ssp_pkg::S_CLEAR;
                end
            end
            ssp_pkg::S_CLEAR: begin
                if (at_last) begin
                    n_state = ssp_pkg::S_ROOT;
                end
            end
            ssp_pkg::S_ROOT: begin
                n_state = root_ok ? ssp_pkg::S_SCAN : ssp_pkg::S_OUT_RD;
            end
            ssp_pkg::S_SCAN: begin
                if (at_last) begin
                    n_state = ssp_pkg::S_SCAN_LAST;
                end
            end
            ssp_pkg::S_SCAN_LAST: begin
                n_state = n_found ? ssp_pkg::S_SETTLE : ssp_pkg::S_OUT_RD;
            end
            ssp_pkg::S_SETTLE: begin
                n_state = ssp_pkg::S_EDGE_RD;
            end
            ssp_pkg::S_EDGE_RD: begin
                n_state = edges_done ? ssp_pkg::S_SCAN : ssp_pkg::S_EDGE_CHK;
            end
            ssp_pkg::S_EDGE_CHK: begin
                n_state = edge_hit ? ssp_pkg::S_NODE_UPD : ssp_pkg::S_EDGE_RD;
            end
            ssp_pkg::S_NODE_UPD: begin
                n_state = ssp_pkg::S_EDGE_RD;
            end
            ssp_pkg::S_OUT_RD: begin
                if (out_free) begin
                    n_state = ssp_pkg::S_OUT_LD;
                end
            end
            ssp_pkg::S_OUT_LD: begin
                n_state = at_last ? ssp_pkg::S_IDLE : ssp_pkg::S_OUT_RD;
            end
            default: begin
                n_state = ssp_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------------
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = r_stored[EDGE_AW-1:0];
        edge_wdata = '{src: i_in_data.from_node, dst: i_in_data.to_node,
                       weight: i_in_data.edge_cost};
        edge_re    = 1'b0;
        edge_raddr = r_eidx[EDGE_AW-1:0];
        node_we    = 1'b0;
        node_waddr = r_nidx[NODE_W-1:0];
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = r_nidx[NODE_W-1:0];
        unique case (r_state)
            ssp_pkg::S_IDLE: begin
                edge_we = in_fire && (i_in_data.kind == ssp_pkg::KIND_ADD) &&
                          (r_stored < ECNT_W'(MAX_EDGES));
            end
            ssp_pkg::S_CLEAR: begin
                node_we = 1'b1;
            end
            ssp_pkg::S_ROOT: begin
                node_we    = root_ok;
                node_waddr = NODE_W'(r_root);
                node_wdata = '{settled: 1'b0, reached: 1'b1, path_cost: '0};
            end
            ssp_pkg::S_SCAN: begin
                node_re = 1'b1;
            end
            ssp_pkg::S_SETTLE: begin
                node_we    = 1'b1;
                node_waddr = r_pick;
                node_wdata = '{settled: 1'b1, reached: 1'b1, path_cost: r_best_dist};
            end
            ssp_pkg::S_EDGE_RD: begin
                edge_re = !edges_done;
            end
            ssp_pkg::S_EDGE_CHK: begin
                node_re    = edge_hit;
                node_raddr = NODE_W'(edge_rd.dst);
            end
            ssp_pkg::S_NODE_UPD: begin
                node_we    = !node_rd.reached || (r_nd < node_rd.path_cost);
                node_waddr = r_dst;
                node_wdata = '{settled: node_rd.settled, reached: 1'b1, path_cost: r_nd};
            end
            ssp_pkg::S_OUT_RD: begin
                node_re = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ssp_pkg::S_IDLE;
            r_node_count <= ssp_pkg::NODE_COUNT_RESET;
            r_stored     <= '0;
            r_out_valid  <= 1'b0;
            r_scan_v     <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan_v <= (r_state == ssp_pkg::S_SCAN);

            if (cfg_write) begin
                r_node_count <= pwdata[ssp_pkg::COUNT_REG_W-1:0];
            end

            if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            case (r_state) inside
                ssp_pkg::S_IDLE: begin
                    if (in_fire) begin
                        case (i_in_data.kind)
                            ssp_pkg::KIND_ADD: begin
                                if (r_stored < ECNT_W'(MAX_EDGES)) begin
                                    r_stored <= r_stored + ECNT_W'(1);
                                end
                            end
                            ssp_pkg::KIND_CLEAR: begin
                                r_stored <= '0;
                            end
                            ssp_pkg::KIND_RUN: begin
                                r_count <= run_count;
                                r_root  <= i_in_data.root_node;
                                r_nidx  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ssp_pkg::S_CLEAR: begin
                    r_nidx <= r_nidx + CNT_W'(1);
                end
                ssp_pkg::S_ROOT: begin
                    r_nidx  <= '0;
                    r_found <= 1'b0;
                end
                ssp_pkg::S_SCAN, ssp_pkg::S_SCAN_LAST: begin
                    if (r_state == ssp_pkg::S_SCAN) begin
                        r_scan_idx <= r_nidx[NODE_W-1:0];
                        r_nidx     <= r_nidx + CNT_W'(1);
                    end else begin
                        r_nidx <= '0;
                    end
                    if (scan_take) begin
                        r_found     <= 1'b1;
                        r_pick      <= r_scan_idx;
                        r_best_dist <= node_rd.path_cost;
                    end
                end
                ssp_pkg::S_SETTLE: begin
                    r_eidx <= '0;
                end
                ssp_pkg::S_EDGE_RD: begin
                    if (edges_done) begin
                        r_nidx  <= '0;
                        r_found <= 1'b0;
                    end
                end
                ssp_pkg::S_EDGE_CHK: begin
                    r_nd  <= cand_dist;
                    r_dst <= NODE_W'(edge_rd.dst);
                    if (!edge_hit) begin
                        r_eidx <= r_eidx + ECNT_W'(1);
                    end
                end
                ssp_pkg::S_NODE_UPD: begin
                    r_eidx <= r_eidx + ECNT_W'(1);
                end
                ssp_pkg::S_OUT_LD: begin
                    r_out_valid      <= 1'b1;
                    r_out.node_index <= ssp_pkg::NODE_FIELD_W'(r_nidx);
                    r_out.distance   <= node_rd.reached ? node_rd.path_cost : '0;
                    r_out.reachable  <= node_rd.reached;
                    r_out.last       <= at_last;
                    r_nidx           <= r_nidx + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_stored) <= 32'(MAX_EDGES))
        else $error("edge count beyond store capacity");

    a_out_reg_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssp_pkg::S_OUT_LD) |-> !r_out_valid)
        else $error("result register overwritten before it was taken");

    a_idle_no_node_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssp_pkg::S_IDLE) |-> !node_we)
        else $error("node memory written while idle");

    a_settle_after_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssp_pkg::S_SETTLE) |-> r_found)
        else $error("node settled without a scan pick");
`endif

endmodule

/* hdl/ssp_ram.sv */
// ----------------------------------------------------------------------------
// Shortest path unit RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
